// ===== rtl/core/hll_pkg.sv =====
package hll_pkg;

  localparam int MaxPrecision     = 14;
  localparam int MinPrecision     = 4;
  localparam int DefaultPrecision = 14;
  localparam int HashW            = 64;
  localparam int RankW            = 6;
  localparam int FracBits         = 47;
  localparam int SumW             = 64;
  localparam int IndexW           = 14;
  localparam int EmptyW           = 15;
  localparam int CfgW             = 4;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_MERGE  = 1'b1
  } hll_cmd_e;

  typedef struct packed {
    logic                cmd;
    logic [HashW-1:0]    element_hash;
    logic [IndexW-1:0]   merge_index;
    logic [RankW-1:0]    merge_rank;
  } in_req_t;

  typedef struct packed {
    logic [IndexW-1:0]   touched_index;
    logic [RankW-1:0]    new_rank;
    logic                changed;
    logic [SumW-1:0]     harmonic_sum;
    logic [EmptyW-1:0]   empty_count;
  } out_rsp_t;

  typedef struct packed {
    logic cfg_load;
    logic clr_step;
    logic load_in;
    logic calc;
    logic upd;
    logic add;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_status_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CALC  = 6'b000100,
    S_UPD   = 6'b001000,
    S_ADD   = 6'b010000,
    S_DONE  = 6'b100000
  } hll_state_e;

  // 2^-r in 17.47, zero once below the last fraction bit
  function automatic logic [SumW-1:0] term_of(input logic [RankW-1:0] r);
    logic [SumW-1:0] t;
    if (r > RankW'(FracBits)) begin
      t = '0;
    end else begin
      t = SumW'(1) << (RankW'(FracBits) - r);
    end
    return t;
  endfunction

  // trailing zero count, binary search in six steps
  function automatic logic [6:0] ctz64(input logic [HashW-1:0] v);
    logic [HashW-1:0] x;
    logic [6:0]       n;
    x = v;
    n = '0;
    if (x[31:0] == '0) begin n = n + 7'd32; x = x >> 32; end
    if (x[15:0] == '0) begin n = n + 7'd16; x = x >> 16; end
    if (x[7:0] == '0)  begin n = n + 7'd8;  x = x >> 8;  end
    if (x[3:0] == '0)  begin n = n + 7'd4;  x = x >> 4;  end
    if (x[1:0] == '0)  begin n = n + 7'd2;  x = x >> 2;  end
    if (x[0] == 1'b0)  begin n = n + 7'd1;  end
    return n;
  endfunction

endpackage

// ===== rtl/core/hll_ctrl.sv =====
module hll_ctrl import hll_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  hll_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
    if (cfg_we_i) begin
      cmd_o.cfg_load = 1'b1;
      state_d        = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/hll_datapath.sv =====
module hll_datapath import hll_pkg::*; #(
  parameter int MAX_PRECISION = MaxPrecision
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  in_req_t         in_req_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output out_rsp_t        out_rsp_o,
  input  ctrl_cmd_t       cmd_i,
  output dp_status_t      status_o
);

  localparam int IdxW    = MAX_PRECISION;
  localparam int Depth   = 1 << MAX_PRECISION;
  localparam int PrecW   = $clog2(MAX_PRECISION + 1);
  localparam int CntW    = MAX_PRECISION + 1;
  localparam int RstPrec = (MAX_PRECISION < DefaultPrecision) ? MAX_PRECISION
                                                              : DefaultPrecision;

  logic [RankW-1:0] mem [Depth];

  logic [PrecW-1:0] prec_q;
  logic [SumW-1:0]  sum_q;
  logic [CntW-1:0]  zero_q;
  logic [IdxW-1:0]  cnt_q;
  in_req_t          in_q;
  logic [IdxW-1:0]  idx_q;
  logic [RankW-1:0] rank_q;
  logic [RankW-1:0] rdata_q;
  logic             chg_q;
  logic [RankW-1:0] newrank_q;
  logic             out_valid_q;
  out_rsp_t         rsp_q;

  logic [PrecW-1:0]    prec_new;
  logic [IdxW-1:0]     idx_mask;
  logic [IdxW-1:0]     hash_top;
  logic [IdxW+IndexW-1:0] merge_ext;
  logic [IdxW-1:0]     idx_c;
  logic [HashW-1:0]    rest_mask;
  logic [HashW-1:0]    rest;
  logic [6:0]          tz;
  logic [RankW-1:0]    rank_c;
  logic                chg;
  logic [IdxW+IndexW-1:0] touched_ext;
  logic [CntW+EmptyW-1:0] empty_ext;

  // clamp of the written precision
  always_comb begin
    if (cfg_wdata_i < CfgW'(MinPrecision)) begin
      prec_new = PrecW'(MinPrecision);
    end else if ({1'b0, cfg_wdata_i} > 5'(MAX_PRECISION)) begin
      prec_new = PrecW'(MAX_PRECISION);
    end else begin
      prec_new = PrecW'(cfg_wdata_i);
    end
  end

  assign idx_mask  = ~({IdxW{1'b1}} << prec_q);
  assign hash_top  = in_q.element_hash[HashW-1 -: IdxW];
  assign merge_ext = {{IdxW{1'b0}}, in_q.merge_index};

  always_comb begin
    for (int i = 0; i < HashW; i++) begin
      rest_mask[i] = (7'(i) < (7'd64 - 7'(prec_q)));
    end
  end

  assign rest = in_q.element_hash & rest_mask;
  assign tz   = ctz64(rest);

  always_comb begin
    if (in_q.cmd == CMD_MERGE) begin
      idx_c  = merge_ext[IdxW-1:0] & idx_mask;
      rank_c = in_q.merge_rank;
    end else begin
      idx_c = (hash_top >> (PrecW'(MAX_PRECISION) - prec_q)) & idx_mask;
      if (rest == '0) begin
        rank_c = RankW'(7'd65 - 7'(prec_q));
      end else begin
        rank_c = RankW'(tz + 7'd1);
      end
    end
  end

  assign chg = rank_q > rdata_q;

  // rank store: clearing pass or update write, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step && !cmd_i.cfg_load) begin
      mem[cnt_q] <= '0;
    end else if (cmd_i.upd && chg) begin
      mem[idx_q] <= rank_q;
    end
    if (cmd_i.calc) begin
      rdata_q <= mem[idx_c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_req_i;
    end
    if (cmd_i.calc) begin
      idx_q  <= idx_c;
      rank_q <= rank_c;
    end
    if (cmd_i.upd) begin
      chg_q     <= chg;
      newrank_q <= chg ? rank_q : rdata_q;
    end
    if (cmd_i.load_out) begin
      rsp_q.touched_index <= touched_ext[IndexW-1:0];
      rsp_q.new_rank      <= newrank_q;
      rsp_q.changed       <= chg_q;
      rsp_q.harmonic_sum  <= sum_q;
      rsp_q.empty_count   <= empty_ext[EmptyW-1:0];
    end
  end

  assign touched_ext = {{IndexW{1'b0}}, idx_q};
  assign empty_ext   = {{EmptyW{1'b0}}, zero_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q <= PrecW'(RstPrec);
      sum_q  <= SumW'(1) << (RstPrec + FracBits);
      zero_q <= CntW'(1) << RstPrec;
      cnt_q  <= '0;
    end else if (cmd_i.cfg_load) begin
      prec_q <= prec_new;
      sum_q  <= SumW'(1) << (7'(prec_new) + 7'(FracBits));
      zero_q <= CntW'(1) << prec_new;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
      if (cmd_i.upd && chg) begin
        sum_q <= sum_q - term_of(rdata_q);
        if (rdata_q == '0 && zero_q != '0) begin
          zero_q <= zero_q - CntW'(1);
        end
      end
      if (cmd_i.add && chg_q) begin
        sum_q <= sum_q + term_of(rank_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.clr_last = (cnt_q == idx_mask);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_rsp_o         = rsp_q;

endmodule

// ===== rtl/core/hyperloglog_register_update.sv =====
// HyperLogLog register update.
// Input channel: in_valid_i / in_ready_o with an in_req_t request, either an
// insert (64-bit element hash) or a merge (register index and rank).
// Output channel: out_valid_o / out_ready_i with one out_rsp_t per request:
// touched register, its new rank, changed flag, harmonic sum (17.47) and
// empty register count.
// Configuration: cfg_we_i writes cfg_wdata_i as the precision p, clamped to
// 4..MAX_PRECISION, and empties the sketch.
// Timing: an accepted request steps through the read, update and sum states
// (S_CALC, S_UPD, S_ADD) to S_DONE, where its response is registered; no new
// request is accepted until the controller is back in S_IDLE.
// A response waits in the output register while the receiver stalls; the
// next request is accepted meanwhile but finishes only once that register
// frees up.
// Reset, and every precision write, starts a clearing pass over the 2^p
// store entries, during which no request is accepted.
module hyperloglog_register_update import hll_pkg::*; #(
  parameter int MAX_PRECISION = MaxPrecision
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_req_t         in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_rsp_t        out_rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  hll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hll_datapath #(
    .MAX_PRECISION (MAX_PRECISION)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// ===== dv/hll_update_checker.sv =====
module hll_update_checker import hll_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  in_req_t         in_req_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  out_rsp_t        out_rsp_i,
  output int              pending_o,
  output int              fail_count_o
);

  logic [RankW-1:0]  ranks [1 << MaxPrecision];
  logic [SumW-1:0]   sum_now;
  logic [EmptyW-1:0] empty_now;
  int unsigned       prec;
  out_rsp_t          sketch_rsp_q [$];
  out_rsp_t          want_rsp;
  out_rsp_t          next_rsp;
  int unsigned       new_prec;
  int                mismatches = 0;
  int                in_flight  = 0;

  assign pending_o    = in_flight;
  assign fail_count_o = mismatches;

  function automatic logic [SumW-1:0] weight(input int unsigned r);
    if (r > FracBits) return '0;
    return SumW'(1) << (FracBits - r);
  endfunction

  function automatic int unsigned hash_rank(input logic [HashW-1:0] h, input int unsigned p);
    logic [HashW-1:0] rest;
    int unsigned      r;
    rest = h & ({HashW{1'b1}} >> p);
    r    = 1;
    while (r <= HashW - p && !rest[0]) begin
      r++;
      rest = rest >> 1;
    end
    return r;
  endfunction

  task automatic empty_sketch(input int unsigned p);
    prec = p;
    foreach (ranks[i]) ranks[i] = '0;
    sum_now   = SumW'(1) << (p + FracBits);
    empty_now = EmptyW'(1) << p;
  endtask

  task automatic apply_request(input in_req_t req, output out_rsp_t rsp);
    int unsigned idx;
    int unsigned r;
    int unsigned old;
    int unsigned mask;
    mask = (1 << prec) - 1;
    rsp  = '0;
    if (req.cmd == CMD_INSERT) begin
      idx = 32'(req.element_hash >> (HashW - prec)) & mask;
      r   = hash_rank(req.element_hash, prec);
    end else begin
      idx = 32'(req.merge_index) & mask;
      r   = req.merge_rank;
    end
    old = ranks[idx];
    if (r > old) begin
      ranks[idx] = RankW'(r);
      sum_now    = sum_now - weight(old) + weight(r);
      if (old == 0 && empty_now != 0) empty_now--;
      rsp.changed = 1'b1;
    end
    rsp.touched_index = IndexW'(idx);
    rsp.new_rank      = ranks[idx];
    rsp.harmonic_sum  = sum_now;
    rsp.empty_count   = empty_now;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_sketch(DefaultPrecision);
      sketch_rsp_q.delete();
    end else begin
      if (cfg_we_i) begin
        new_prec = cfg_wdata_i;
        if (new_prec < MinPrecision) new_prec = MinPrecision;
        if (new_prec > MaxPrecision) new_prec = MaxPrecision;
        empty_sketch(new_prec);
      end
      // response first: a request accepted on this edge cannot be answered yet
      if (out_valid_i && out_ready_i) begin
        if (sketch_rsp_q.size() == 0) begin
          $error("response with no request outstanding: index 0x%0h",
                 out_rsp_i.touched_index);
          mismatches++;
        end else begin
          want_rsp = sketch_rsp_q.pop_front();
          check_field("touched_index", want_rsp.touched_index, out_rsp_i.touched_index);
          check_field("new_rank", want_rsp.new_rank, out_rsp_i.new_rank);
          check_field("changed", want_rsp.changed, out_rsp_i.changed);
          check_field("harmonic_sum", want_rsp.harmonic_sum, out_rsp_i.harmonic_sum);
          check_field("empty_count", want_rsp.empty_count, out_rsp_i.empty_count);
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_request(in_req_i, next_rsp);
        sketch_rsp_q.push_back(next_rsp);
      end
    end
    in_flight = sketch_rsp_q.size();
  end

endmodule

// ===== dv/tb_hyperloglog_register_update.sv =====
module tb_hyperloglog_register_update;
  import hll_pkg::*;

  localparam int WatchdogLimit = 100000;
  localparam int HoldCycles    = 300;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_wdata;
  logic            in_valid;
  logic            in_ready;
  in_req_t         in_req;
  logic            out_valid;
  logic            out_ready;
  out_rsp_t        out_rsp;
  int              pending;
  int              fails;

  logic            steady       = 1'b0;
  logic            hold_off_req = 1'b0;
  int unsigned     cur_prec     = DefaultPrecision;

  hyperloglog_register_update dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  hll_update_checker sketch_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_rsp_i    (out_rsp),
    .pending_o    (pending),
    .fail_count_o (fails)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic in_req_t insert_req(input logic [HashW-1:0] h);
    in_req_t r;
    r              = '0;
    r.cmd          = CMD_INSERT;
    r.element_hash = h;
    return r;
  endfunction

  function automatic in_req_t merge_req(input int unsigned idx, input int unsigned rank);
    in_req_t r;
    r             = '0;
    r.cmd         = CMD_MERGE;
    r.merge_index = IndexW'(idx);
    r.merge_rank  = RankW'(rank);
    return r;
  endfunction

  function automatic in_req_t random_req(input int unsigned p);
    in_req_t          r;
    logic [HashW-1:0] h;
    int unsigned      idx;
    r.element_hash = {$urandom, $urandom};
    r.merge_index  = IndexW'($urandom);
    r.merge_rank   = RankW'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      r.cmd = CMD_INSERT;
      h     = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0:       h = h & ~({HashW{1'b1}} >> p);
        1, 2, 3: h = h & ({HashW{1'b1}} << $urandom_range(1, 63));
        default: ;
      endcase
      // crowd onto a few registers so ranks climb and collide
      if ($urandom_range(0, 1) == 1)
        h = (HashW'($urandom_range(0, 7)) << (HashW - p)) | (h & ({HashW{1'b1}} >> p));
      r.element_hash = h;
    end else begin
      r.cmd = CMD_MERGE;
      if ($urandom_range(0, 1) == 1) r.merge_rank = RankW'($urandom_range(0, 8));
      if ($urandom_range(0, 1) == 1) begin
        idx           = ($urandom & ~((1 << p) - 1)) | $urandom_range(0, 7);
        r.merge_index = IndexW'(idx);
      end
    end
    return r;
  endfunction

  task automatic send(input in_req_t r);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic set_precision(input logic [CfgW-1:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_prec = (v < MinPrecision) ? MinPrecision : ((v > MaxPrecision) ? MaxPrecision : v);
  endtask

  task automatic random_run(input int n, input logic with_hold);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if (with_hold && i == n / 2) hold_off_req = 1'b1;
      send(random_req(cur_prec));
    end
    steady = 1'b0;
  endtask

  // receiver
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap          = HoldCycles;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 6);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("hyperloglog_register_update verification failed");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_req    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // precision 14 after reset
    send(insert_req(64'h0002_0000_0000_0000));   // rank 50, term below resolution
    send(insert_req(64'h0));                     // no remaining bits: cap rank
    send(insert_req(64'h1));                     // lower rank, no change
    send(insert_req({HashW{1'b1}}));
    send(insert_req(64'h8000_0000_0000_0000));
    send(insert_req(64'h0004_0000_0000_0000));
    send(merge_req(5, 63));                      // above insert cap
    send(merge_req(5, 0));
    send(merge_req(5, 63));
    send(merge_req(16383, 1));
    send(merge_req(100, 47));
    send(merge_req(101, 48));
    send(merge_req(102, 1));
    send(merge_req(102, 2));

    set_precision(4'd0);                         // clamps to 4
    send(merge_req(16383, 3));                   // index wraps to 15
    send(insert_req(64'h0));
    send(insert_req({HashW{1'b1}}));
    send(insert_req(64'h0800_0000_0000_0000));
    send(merge_req(16, 63));
    random_run(300, 1'b1);

    set_precision(4'd15);                        // clamps to 14
    random_run(200, 1'b0);
    set_precision(4'd14);
    random_run(150, 1'b0);
    set_precision(4'd5);
    random_run(300, 1'b0);
    set_precision(4'd3);
    random_run(250, 1'b1);
    set_precision(4'd10);
    random_run(200, 1'b0);
    set_precision(4'd7);
    random_run(250, 1'b0);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("hyperloglog_register_update verification clean");
    end else begin
      $display("hyperloglog_register_update verification failed");
    end
    $finish;
  end

endmodule
